// ===== design/mcid_pkg.sv =====
// shared types and constants of the multichannel input debouncer
`default_nettype none
package mcid_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int PIN_W        = 16;
  localparam int PERIOD_W     = 16;
  localparam int THR_W        = 8;
  localparam int ELAPSED_W    = 8;
  localparam int CD_W         = 18;
  localparam int HANDLE_W     = 4;
  localparam int CH_W         = 4;
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 40;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef struct packed {
    logic tick;
    logic add;
    logic start;
    logic stop;
  } lane_cmd_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] handle;
  } ctrl_res_t;

endpackage
`default_nettype wire

// ===== design/mcid_lane.sv =====
// one debounce lane: countdown, sampling, stable count and event detection
`default_nettype none
module mcid_lane
  import mcid_pkg::*;
(
  input  wire logic                 clk,
  input  wire lane_cmd_t            cmd,
  input  wire logic [PERIOD_W-1:0]  period,
  input  wire logic [THR_W-1:0]     threshold,
  input  wire logic                 initial_level,
  input  wire logic [ELAPSED_W-1:0] elapsed,
  input  wire logic                 pin,
  output logic                      fire,
  output logic                      sample_level
);

  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [THR_W-1:0]      thr_r, thr_nxt;
  logic signed [CD_W-1:0] cd_r, cd_nxt;
  logic [THR_W-1:0]      stable_r, stable_nxt;
  logic                  last_r, last_nxt;
  logic                  pend_r, pend_nxt;
  logic                  active_r, active_nxt;

  logic signed [CD_W-1:0] cd_dec;
  logic                   sampled;
  logic                   arm;
  logic [PERIOD_W-1:0]    arm_period;
  logic [THR_W-1:0]       stable_upd;
  logic                   pend_upd;

  assign cd_dec     = cd_r - $signed({{(CD_W-ELAPSED_W){1'b0}}, elapsed});
  assign sampled    = cmd.tick && active_r && (cd_dec[CD_W-1] || (cd_dec == '0));
  assign arm        = cmd.add || (cmd.start && !active_r);
  assign arm_period = cmd.add ? period : period_r;

  always_comb begin
    period_nxt = period_r;
    thr_nxt    = thr_r;
    cd_nxt     = cd_r;
    stable_nxt = stable_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    active_nxt = active_r;
    stable_upd = stable_r;
    pend_upd   = pend_r;
    fire       = 1'b0;
    if (cmd.add) begin
      period_nxt = period;
      thr_nxt    = threshold;
    end
    if (arm) begin
      last_nxt   = initial_level;
      pend_nxt   = 1'b0;
      stable_nxt = '0;
      cd_nxt     = $signed({{(CD_W-PERIOD_W){1'b0}}, arm_period});
      active_nxt = 1'b1;
    end else if (cmd.stop) begin
      active_nxt = 1'b0;
    end else if (cmd.tick && active_r) begin
      if (sampled) begin
        cd_nxt = $signed({{(CD_W-PERIOD_W){1'b0}}, period_r});
        if (pin != last_r) begin
          stable_upd = '0;
          pend_upd   = ~pend_r;
          last_nxt   = pin;
        end else if (pend_r) begin
          stable_upd = stable_r + 1'b1;
        end
        if (stable_upd >= thr_r) begin
          fire       = 1'b1;
          stable_upd = '0;
          pend_upd   = 1'b0;
        end
        stable_nxt = stable_upd;
        pend_nxt   = pend_upd;
      end else begin
        cd_nxt = cd_dec;
      end
    end
  end

  assign sample_level = sampled && pin;

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    thr_r    <= thr_nxt;
    cd_r     <= cd_nxt;
    stable_r <= stable_nxt;
    last_r   <= last_nxt;
    pend_r   <= pend_nxt;
    active_r <= active_nxt;
  end

endmodule
`default_nettype wire

// ===== design/mcid_ctrl.sv =====
// op decoder, channel count and per-lane command fan-out
`default_nettype none
module mcid_ctrl
  import mcid_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [1:0]        op,
  input  wire logic [CH_W-1:0]   channel,
  output lane_cmd_t              cmd [CHANNELS],
  output ctrl_res_t              res
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int IDX_W = (CNT_W > CH_W) ? CNT_W : CH_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ch_w;
  logic [IDX_W-1:0] count_w;
  logic             full;
  logic             ch_ok;
  op_t              op_d;

  assign op_d    = op_t'(op);
  assign ch_w    = IDX_W'(channel);
  assign count_w = IDX_W'(count_r);
  assign full    = (count_r == CNT_W'(CHANNELS));
  assign ch_ok   = (ch_w < count_w);

  always_comb begin
    count_nxt  = count_r;
    res.status = 1'b0;
    res.handle = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      cmd[k] = '0;
    end
    unique case (op_d)
      OP_TICK: begin
        for (int k = 0; k < CHANNELS; k++) begin
          cmd[k].tick = accept && (IDX_W'(k) < count_w);
        end
      end
      OP_ADD: begin
        if (full) begin
          res.status = 1'b1;
        end else begin
          res.handle = HANDLE_W'(count_r);
          if (accept) begin
            count_nxt = count_r + 1'b1;
          end
          for (int k = 0; k < CHANNELS; k++) begin
            cmd[k].add = accept && (IDX_W'(k) == count_w);
          end
        end
      end
      OP_START: begin
        res.status = !ch_ok;
        for (int k = 0; k < CHANNELS; k++) begin
          cmd[k].start = accept && ch_ok && (IDX_W'(k) == ch_w);
        end
      end
      OP_STOP: begin
        res.status = !ch_ok;
        for (int k = 0; k < CHANNELS; k++) begin
          cmd[k].stop = accept && ch_ok && (IDX_W'(k) == ch_w);
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/mcid_merge.sv =====
// merges lane events with the op status into the registered result beat
`default_nettype none
module mcid_merge
  import mcid_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire ctrl_res_t             res,
  input  wire logic [CHANNELS-1:0]   fire,
  input  wire logic [CHANNELS-1:0]   sample_level,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [PIN_W-1:0]      emask, elev;
  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r;

  for (genvar k = 0; k < PIN_W; k++) begin : g_bits
    if (k < CHANNELS) begin : g_on
      assign emask[k] = fire[k];
      assign elev[k]  = sample_level[k];
    end else begin : g_off
      assign emask[k] = 1'b0;
      assign elev[k]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= {3'b000, elev, emask, res.handle, res.status};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

// ===== design/multi_channel_input_debouncer_core.sv =====
// top level of the multichannel input debouncer
//
// input stream: one beat per command (tick, add, start, stop); every
// accepted beat yields exactly one result beat on the output stream.
// a tick beat carries elapsed time and all pin levels; each registered
// channel runs in its own lane and updates in the cycle the beat is taken.
// add hands out the next free channel in order; start and stop switch a
// registered channel on or off.
// result beats come from the output register, the cycle after the input
// beat is taken. throughput: one beat per cycle while out_tready is high,
// set by the single output register; a new beat is taken when no result
// is held or the held result is taken in the same cycle. on a stall, the
// result stays in the output register and in_tready drops until taken.
// reset clears the channel count and the output valid; per-channel state
// is written by add before it is ever read.
// result tdata: status, handle, event mask, event levels (low bits first).
`default_nettype none
module multi_channel_input_debouncer_core
  import mcid_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // op[1:0], channel[5:2], period[21:6], threshold[29:22], initial_level[30],
  // read_period[38:31], pin_levels[54:39], zero pad[55]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status[0], handle[4:1], event_mask[20:5], event_levels[36:21], zero pad[39:37]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic                  accept;
  logic [1:0]            op;
  logic [CH_W-1:0]       channel;
  logic [PERIOD_W-1:0]   period;
  logic [THR_W-1:0]      threshold;
  logic                  initial_level;
  logic [ELAPSED_W-1:0]  read_period;
  logic [PIN_W-1:0]      pin_levels;
  lane_cmd_t             cmd [CHANNELS];
  ctrl_res_t             res;
  logic [CHANNELS-1:0]   fire;
  logic [CHANNELS-1:0]   sample_level;

  assign op            = in_tdata[1:0];
  assign channel       = in_tdata[5:2];
  assign period        = in_tdata[21:6];
  assign threshold     = in_tdata[29:22];
  assign initial_level = in_tdata[30];
  assign read_period   = in_tdata[38:31];
  assign pin_levels    = in_tdata[54:39];

  assign in_tready = !out_tvalid || out_tready;
  assign accept    = in_tvalid && in_tready;

  mcid_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .op      (op),
    .channel (channel),
    .cmd     (cmd),
    .res     (res)
  );

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    logic pin;
    if (k < PIN_W) begin : g_pin
      assign pin = pin_levels[k];
    end else begin : g_nopin
      assign pin = 1'b0;
    end

    mcid_lane u_lane (
      .clk           (clk),
      .cmd           (cmd[k]),
      .period        (period),
      .threshold     (threshold),
      .initial_level (initial_level),
      .elapsed       (read_period),
      .pin           (pin),
      .fire          (fire[k]),
      .sample_level  (sample_level[k])
    );
  end

  mcid_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .res          (res),
    .fire         (fire),
    .sample_level (sample_level),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_tdata    (out_tdata)
  );

endmodule
`default_nettype wire
